/* sv/deq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Sizes, operation codes, ring arithmetic and the control/result structs.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed port widths
    localparam int KIND_W     = 3;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 5;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

    // Store access issued for one transfer
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] wdata;
    } deq_acc_t;

    // Status of one operation
    typedef struct packed {
        logic             ok;
        logic             pop;
        logic [CNT_W-1:0] count;
    } deq_res_t;

    // (base + off) mod DEPTH; base < DEPTH and off <= DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
            sum = sum - (CNT_W+1)'(DEPTH);
        return ADDR_W'(sum);
    endfunction

endpackage
`default_nettype wire

/* sv/deq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram: generic single-port synchronous RAM
// One write and/or one read per cycle on one address; read data registered, held between reads.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= wdata;
        if (rd_en)
            rdata <= mem[addr];
    end

endmodule
`default_nettype wire

/* sv/deq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl: front pointer and element count of the ring
// Decodes the operation, issues the store access and updates the pointer and count.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [deq_pkg::KIND_W-1:0]    kind,
    input  wire logic [deq_pkg::WORD_W-1:0]    data,
    output deq_pkg::deq_acc_t                  acc,
    output deq_pkg::deq_res_t                  res
);
    import deq_pkg::*;

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              full, empty;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Operation decode
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        acc.wr_en  = 1'b0;
        acc.rd_en  = 1'b0;
        acc.addr   = front_reg;
        acc.wdata  = DATA_WIDTH'(data);
        res.ok     = 1'b0;
        res.pop    = 1'b0;
        case (kind)
            KIND_PUSH_FRONT:
            begin
                if (!full)
                begin
                    front_next = (front_reg == '0) ? ADDR_W'(DEPTH - 1)
                                                   : front_reg - 1'b1;
                    acc.addr   = front_next;
                    acc.wr_en  = 1'b1;
                    count_next = count_reg + 1'b1;
                    res.ok     = 1'b1;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (!full)
                begin
                    acc.addr   = ring_add(front_reg, count_reg);
                    acc.wr_en  = 1'b1;
                    count_next = count_reg + 1'b1;
                    res.ok     = 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (!empty)
                begin
                    acc.addr   = front_reg;
                    acc.rd_en  = 1'b1;
                    front_next = ring_add(front_reg, CNT_W'(1));
                    count_next = count_reg - 1'b1;
                    res.ok     = 1'b1;
                    res.pop    = 1'b1;
                end
            end
            KIND_POP_BACK:
            begin
                if (!empty)
                begin
                    acc.addr   = ring_add(front_reg, count_reg - 1'b1);
                    acc.rd_en  = 1'b1;
                    count_next = count_reg - 1'b1;
                    res.ok     = 1'b1;
                    res.pop    = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
                res.ok     = 1'b1;
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase
        // only a real transfer touches the store
        acc.wr_en = acc.wr_en & accept;
        acc.rd_en = acc.rd_en & accept;
        res.count = count_next;
    end

    // Pointer and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

/* sv/double_ended_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of data words in a ring store
// Top level: input handshake, result pipeline and the store RAM.
// ----------------------------------------------------------------------------
// At the transfer edge the status of an operation is latched in the pending
// register while the single-port store does its registered read. The output
// register loads from the pending register once the output side is free, and
// the result is then valid. A new operation can be taken every cycle: the front
// pointer and count update at the transfer, and the store port is used once
// per operation, so the sustained rate is one item per clock while the
// result side keeps taking. Pops on an empty deque and pushes on a full one
// return ok low with the state unchanged. Clear only resets the pointer and
// count; there is no clearing pass after reset.
module double_ended_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [deq_pkg::KIND_W-1:0]  kind,
    input  wire logic [deq_pkg::WORD_W-1:0]  data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [deq_pkg::WORD_W-1:0]  data_out,
    output logic                             ok,
    output logic      [deq_pkg::COUNT_W-1:0] count,
    output logic                             empty_res
);
    import deq_pkg::*;

    logic                  accept;
    logic                  pend_move;
    deq_acc_t              acc;
    deq_res_t              res;
    logic [DATA_WIDTH-1:0] rdata;

    logic                  pend_valid_reg, pend_valid_next;
    deq_res_t              pend_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  out_ok_reg;
    logic [CNT_W-1:0]      out_count_reg;

    // Handshake
    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_valid_reg || pend_move;
    assign accept    = in_valid && in_ready;

    deq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (kind),
        .data   (data),
        .acc    (acc),
        .res    (res)
    );

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .wr_en (acc.wr_en),
        .rd_en (acc.rd_en),
        .addr  (acc.addr),
        .wdata (acc.wdata),
        .rdata (rdata)
    );

    // Valid flags
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
            pend_valid_next = 1'b1;
        else if (pend_move)
            pend_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (pend_move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Pending status and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= res;
        if (pend_move)
        begin
            out_data_reg  <= pend_reg.pop ? rdata : '0;
            out_ok_reg    <= pend_reg.ok;
            out_count_reg <= pend_reg.count;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = WORD_W'(out_data_reg);
    assign ok        = out_ok_reg;
    assign count     = COUNT_W'(out_count_reg);
    assign empty_res = (out_count_reg == '0);

endmodule
`default_nettype wire
